>>> design/assert_macros.svh
// assertion macros used by the checker in qefd_check.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define QEFD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define QEFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/qefd_pkg.sv
package qefd_pkg;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 6;
  localparam int COEFF_IN_W = 16;
  localparam int PSIZE_W    = 7;
  localparam int SUM_W      = 32;

  localparam logic [CMD_W-1:0] CMD_WR_COEFF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_BIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENERGY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLIP     = 2'd3;

  localparam logic KIND_ENERGY = 1'b0;
  localparam logic KIND_FLIP   = 1'b1;

  localparam logic [PSIZE_W-1:0] PSIZE_RST = 7'd64;

  // input tdata layout, lowest bit first
  localparam int ROW_LSB    = 0;
  localparam int COL_LSB    = ROW_LSB + POS_W;
  localparam int COEFF_LSB  = COL_LSB + POS_W;
  localparam int BPOS_LSB   = COEFF_LSB + COEFF_IN_W;
  localparam int BVAL_LSB   = BPOS_LSB + POS_W;
  localparam int FLIP_LSB   = BVAL_LSB + 1;
  localparam int IN_FIELD_W = FLIP_LSB + POS_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]             op;
    logic [POS_W-1:0]             row;
    logic [POS_W-1:0]             col;
    logic signed [COEFF_IN_W-1:0] coeff;
    logic [POS_W-1:0]             pos;
    logic                         bval;
    logic [POS_W-1:0]             flip;
    logic                         wr_ok;
    logic                         pos_ok;
    logic                         flip_ok;
  } qefd_req_t;

endpackage

>>> design/qefd_ram.sv
module qefd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/qefd_front.sv
module qefd_front #(
  parameter int MAX_SIZE = 64,
  parameter int CNT_W    = 7
) (
  input  logic [qefd_pkg::IN_TDATA_W-1:0] tdata,
  input  logic [qefd_pkg::CMD_W-1:0]      tuser,
  input  logic [CNT_W-1:0]                n,
  output qefd_pkg::qefd_req_t             req
);

  import qefd_pkg::*;

  always_comb begin
    req.op    = tuser;
    req.row   = tdata[ROW_LSB +: POS_W];
    req.col   = tdata[COL_LSB +: POS_W];
    req.coeff = $signed(tdata[COEFF_LSB +: COEFF_IN_W]);
    req.pos   = tdata[BPOS_LSB +: POS_W];
    req.bval  = tdata[BVAL_LSB];
    req.flip  = tdata[FLIP_LSB +: POS_W];
    // positions past the matrix edge are dropped, flips past n answer zero
    req.wr_ok   = (32'(req.row) < MAX_SIZE) && (32'(req.col) < MAX_SIZE);
    req.pos_ok  = (32'(req.pos) < MAX_SIZE);
    req.flip_ok = (32'(req.flip) < 32'(n));
  end

endmodule

>>> design/qefd_fifo.sv
module qefd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  qefd_pkg::qefd_req_t push_req,
  output logic                pop_valid,
  input  logic                pop_ready,
  output qefd_pkg::qefd_req_t pop_req
);

  import qefd_pkg::*;

  qefd_req_t  slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_req    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> design/qefd_back.sv
module qefd_back #(
  parameter int MAX_SIZE    = 64,
  parameter int COEFF_WIDTH = 16,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CNT_W-1:0]            n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  qefd_pkg::qefd_req_t         q_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qefd_pkg::SUM_W-1:0]  out_sum,
  output logic                        out_kind
);

  import qefd_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_ENERGY = 3'd1;
  localparam logic [ST_W-1:0] ST_FLIP   = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAIN  = 3'd3;
  localparam logic [ST_W-1:0] ST_RESULT = 3'd4;

  localparam int ADDR_W = 2 * IDX_W;

  logic [ST_W-1:0]     state_r, state_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                kind_r, kind_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                gate_r, gate_nxt;
  logic [MAX_SIZE-1:0] spins_r, spins_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [SUM_W-1:0]    out_sum_r, out_sum_nxt;
  logic                out_kind_r, out_kind_nxt;

  logic [CNT_W-1:0]       nm1;
  logic                   j_last, i_last;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [COEFF_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [IDX_W-1:0]       flip_idx, pos_idx;

  assign nm1       = n - CNT_W'(1);
  assign j_last    = (CNT_W'(j_r) == nm1);
  assign i_last    = (CNT_W'(i_r) == nm1);
  assign flip_idx  = IDX_W'(q_req.flip);
  assign pos_idx   = IDX_W'(q_req.pos);
  assign ram_waddr = {IDX_W'(q_req.row), IDX_W'(q_req.col)};
  assign ram_wdata = COEFF_WIDTH'($signed(q_req.coeff));
  assign ram_raddr = {i_r, j_r};
  assign q_ready   = (state_r == ST_IDLE);

  qefd_ram #(
    .WIDTH (COEFF_WIDTH),
    .DEPTH (1 << ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    kind_nxt     = kind_r;
    rd_vld_nxt   = 1'b0;
    gate_nxt     = 1'b0;
    spins_nxt    = spins_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_sum_nxt  = out_sum_r;
    out_kind_nxt = out_kind_r;
    ram_we       = 1'b0;

    // read data arrives the cycle after its address
    if (rd_vld_r && gate_r) begin
      acc_nxt = acc_r + SUM_W'($signed(ram_rdata));
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_req.op)
            CMD_WR_COEFF: begin
              ram_we = q_req.wr_ok;
            end
            CMD_WR_BIT: begin
              if (q_req.pos_ok) begin
                spins_nxt[pos_idx] = q_req.bval;
              end
            end
            CMD_ENERGY: begin
              acc_nxt  = '0;
              neg_nxt  = 1'b0;
              kind_nxt = KIND_ENERGY;
              i_nxt    = '0;
              j_nxt    = '0;
              state_nxt = (n == '0) ? ST_RESULT : ST_ENERGY;
            end
            CMD_FLIP: begin
              acc_nxt  = '0;
              kind_nxt = KIND_FLIP;
              i_nxt    = flip_idx;
              j_nxt    = '0;
              if (q_req.flip_ok) begin
                neg_nxt   = spins_r[flip_idx];
                state_nxt = ST_FLIP;
              end else begin
                neg_nxt   = 1'b0;
                state_nxt = ST_RESULT;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ENERGY: begin
        // walk the upper triangle row by row
        rd_vld_nxt = 1'b1;
        gate_nxt   = spins_r[i_r] && spins_r[j_r];
        if (j_last) begin
          if (i_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
            j_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_FLIP: begin
        rd_vld_nxt = 1'b1;
        gate_nxt   = (j_r == i_r) || spins_r[j_r];
        if (j_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt  = 1'b1;
          out_sum_nxt  = neg_r ? (SUM_W'(0) - acc_r) : acc_r;
          out_kind_nxt = kind_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      spins_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_vld_nxt;
      spins_r   <= spins_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    kind_r     <= kind_nxt;
    gate_r     <= gate_nxt;
    out_sum_r  <= out_sum_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_sum   = out_sum_r;
  assign out_kind  = out_kind_r;

endmodule

>>> design/qubo_energy_and_flip_delta.sv
// coefficient and bit writes: taken while the back end is idle, one request per cycle
// energy query: upper triangle in ST_ENERGY, then ST_DRAIN, ST_RESULT; one matrix read per cycle
// flip delta query: reads one row, out-of-range index gives 0; paced by the single ram read port
// input side runs ahead through a two-entry queue while the back end is busy
// reset (rst_n low, synchronous): spin bits cleared, problem_size set to 64, queue emptied
// the coefficient matrix is not cleared and holds garbage until written
module qubo_energy_and_flip_delta #(
  parameter int MAX_SIZE    = 64,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row, col, coefficient, bit_pos, bit_value, flip_index, zero pad
  input  logic [qefd_pkg::IN_TDATA_W-1:0] in_tdata,
  // command
  input  logic [qefd_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sum_value
  output logic [qefd_pkg::SUM_W-1:0]      out_tdata,
  // query_kind
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qefd_pkg::PSIZE_W-1:0]    cfg_data
);

  import qefd_pkg::*;

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W = $clog2(MAX_SIZE + 1);

  logic [PSIZE_W-1:0] psize_r, psize_nxt;
  logic [CNT_W-1:0]   n_eff;
  qefd_req_t          front_req, q_req;
  logic               q_valid, q_ready;
  logic               out_kind;

  assign cfg_ready = 1'b1;
  assign psize_nxt = (cfg_valid && cfg_ready) ? cfg_data : psize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= PSIZE_RST;
    end else begin
      psize_r <= psize_nxt;
    end
  end

  // sizes above the matrix are clamped
  assign n_eff = (32'(psize_r) > MAX_SIZE) ? CNT_W'(MAX_SIZE) : CNT_W'(psize_r);

  qefd_front #(
    .MAX_SIZE (MAX_SIZE),
    .CNT_W    (CNT_W)
  ) u_front (
    .tdata (in_tdata),
    .tuser (in_tuser),
    .n     (n_eff),
    .req   (front_req)
  );

  qefd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_req   (front_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_req    (q_req)
  );

  qefd_back #(
    .MAX_SIZE    (MAX_SIZE),
    .COEFF_WIDTH (COEFF_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n_eff),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (out_tdata),
    .out_kind  (out_kind)
  );

  assign out_tuser = out_kind;

endmodule

>>> design/qefd_check.sv
`include "assert_macros.svh"

module qefd_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [qefd_pkg::CMD_W-1:0]      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qefd_pkg::SUM_W-1:0]      out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  import qefd_pkg::*;

  logic [7:0] pending_r, pending_nxt;
  logic       query_in, result_out;

  // queries accepted but not yet answered
  assign query_in   = in_tvalid && in_tready &&
                      ((in_tuser == CMD_ENERGY) || (in_tuser == CMD_FLIP));
  assign result_out = out_tvalid && out_tready;
  assign pending_nxt = pending_r + 8'(query_in) - 8'(result_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `QEFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `QEFD_ASSERT_NOW(a_no_spurious, out_tvalid, pending_r != 8'd0,
    "result without a pending query")
  `QEFD_ASSERT_NOW(a_stall_busy, !in_tready, pending_r != 8'd0,
    "input stalled with no query in flight")
  `QEFD_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "config write refused")

endmodule

bind qubo_energy_and_flip_delta qefd_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
